@@ rtl/i2cms_pkg.sv @@
package i2cms_pkg;

  localparam logic [2:0] MODE_START_WR = 3'd0;
  localparam logic [2:0] MODE_START_RD = 3'd1;
  localparam logic [2:0] MODE_WRITE    = 3'd2;
  localparam logic [2:0] MODE_READ     = 3'd3;
  localparam logic [2:0] MODE_STOP     = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NACK    = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] address;
    logic [7:0] data_byte;
    logic       send_nack;
    logic [7:0] slave_sda;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       phase_last;
    logic [7:0] read_data;
    logic       acked;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_BITS,
    ST_ACK,
    ST_STOP,
    ST_IGNORE
  } seq_state_e;

  typedef enum logic [2:0] {
    PK_START,
    PK_WBIT,
    PK_RBIT,
    PK_WACK,
    PK_RACK,
    PK_STOP,
    PK_HOLD
  } phase_kind_e;

  typedef struct packed {
    logic        load;
    logic        emit;
    logic        shift;
    phase_kind_e kind;
    logic [1:0]  phase;
    logic        last;
    logic        acked;
    logic [1:0]  status;
  } ctl_cmd_t;

  typedef struct packed {
    logic nack;
  } dp_stat_t;

endpackage

@@ rtl/i2cms_dp.sv @@
module i2cms_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  i2cms_pkg::req_t  req_i,
  input  i2cms_pkg::ctl_cmd_t cmd_i,
  output i2cms_pkg::dp_stat_t stat_o,
  output i2cms_pkg::rsp_t  rsp_o
);
  import i2cms_pkg::*;

  logic [7:0] shift_q, shift_d;
  logic [7:0] samp_q, samp_d;
  logic       nack_q, nack_d;
  logic       snack_q, snack_d;
  logic       bus_scl_q, bus_sda_q;
  rsp_t       out_q, out_d;
  logic       scl, sda;

  // phase levels
  always_comb begin
    scl = bus_scl_q;
    sda = bus_sda_q;
    case (cmd_i.kind)
      PK_START: begin
        scl = 1'b1;
        sda = ~cmd_i.phase[0];
      end
      PK_WBIT: begin
        scl = cmd_i.phase[0];
        sda = shift_q[7];
      end
      PK_RBIT: begin
        scl = cmd_i.phase[0];
        sda = 1'b1;
      end
      PK_WACK: begin
        scl = (cmd_i.phase == 2'd1);
        sda = 1'b1;
      end
      PK_RACK: begin
        scl = (cmd_i.phase == 2'd1);
        sda = snack_q;
      end
      PK_STOP: begin
        scl = (cmd_i.phase != 2'd0);
        sda = (cmd_i.phase == 2'd2);
      end
      default: begin
        scl = bus_scl_q;
        sda = bus_sda_q;
      end
    endcase
  end

  always_comb begin
    shift_d = shift_q;
    samp_d  = samp_q;
    nack_d  = nack_q;
    snack_d = snack_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      samp_d  = req_i.slave_sda;
      nack_d  = req_i.slave_sda[0];
      snack_d = req_i.send_nack;
      case (req_i.mode)
        MODE_START_WR, MODE_START_RD: shift_d = {req_i.address, req_i.mode[0]};
        MODE_WRITE:                   shift_d = req_i.data_byte;
        default:                      shift_d = '0;
      endcase
    end else if (cmd_i.shift) begin
      shift_d = {shift_q[6:0], (cmd_i.kind == PK_RBIT) & samp_q[7]};
      samp_d  = {samp_q[6:0], 1'b0};
    end
    if (cmd_i.emit) begin
      out_d.scl_level   = scl;
      out_d.sda_release = sda;
      out_d.phase_last  = cmd_i.last;
      out_d.read_data   = (cmd_i.last && cmd_i.kind == PK_RACK) ? shift_q : '0;
      out_d.acked       = cmd_i.acked;
      out_d.status      = cmd_i.status;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    samp_q  <= samp_d;
    nack_q  <= nack_d;
    snack_q <= snack_d;
    out_q   <= out_d;
  end

  // bus levels last driven, idle bus after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_scl_q <= 1'b1;
      bus_sda_q <= 1'b1;
    end else if (cmd_i.emit) begin
      bus_scl_q <= scl;
      bus_sda_q <= sda;
    end
  end

  assign stat_o.nack = nack_q;
  assign rsp_o       = out_q;

endmodule

@@ rtl/i2cms_ctrl.sv @@
module i2cms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          mode_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  i2cms_pkg::dp_stat_t stat_i,
  output i2cms_pkg::ctl_cmd_t cmd_o
);
  import i2cms_pkg::*;

  seq_state_e state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic       open_q, open_d;
  logic       op_rd_q, op_rd_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;
  logic       emit_ok;
  ctl_cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      bit_q       <= '0;
      open_q      <= 1'b0;
      op_rd_q     <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      open_q      <= open_d;
      op_rd_q     <= op_rd_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    bit_d      = bit_q;
    open_d     = open_q;
    op_rd_d    = op_rd_q;
    err_d      = err_q;
    emit_ok    = ~out_valid_q | out_ready_i;
    in_ready_o = (state_q == ST_IDLE);
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.shift  = 1'b0;
    cmd.kind   = PK_HOLD;
    cmd.phase  = phase_q;
    cmd.last   = 1'b0;
    cmd.acked  = 1'b0;
    cmd.status = STAT_OK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          phase_d  = '0;
          bit_d    = '0;
          case (mode_i)
            MODE_START_WR, MODE_START_RD: begin
              state_d = ST_START;
              open_d  = 1'b1;
              op_rd_d = 1'b0;
              err_d   = 1'b0;
            end
            MODE_WRITE: begin
              state_d = open_q ? ST_BITS : ST_IGNORE;
              op_rd_d = 1'b0;
            end
            MODE_READ: begin
              state_d = open_q ? ST_BITS : ST_IGNORE;
              op_rd_d = 1'b1;
            end
            MODE_STOP: begin
              state_d = open_q ? ST_STOP : ST_IGNORE;
              err_d   = 1'b0;
            end
            default: state_d = ST_IGNORE;
          endcase
        end
      end
      ST_START: begin
        if (emit_ok) begin
          cmd.emit = 1'b1;
          cmd.kind = PK_START;
          if (phase_q[0]) begin
            phase_d = '0;
            state_d = ST_BITS;
          end else begin
            phase_d = 2'd1;
          end
        end
      end
      ST_BITS: begin
        cmd.kind = op_rd_q ? PK_RBIT : PK_WBIT;
        if (emit_ok) begin
          cmd.emit  = 1'b1;
          cmd.shift = phase_q[0];
          if (phase_q[0]) begin
            phase_d = '0;
            if (bit_q == 3'd7) begin
              bit_d   = '0;
              state_d = ST_ACK;
            end else begin
              bit_d = bit_q + 3'd1;
            end
          end else begin
            phase_d = 2'd1;
          end
        end
      end
      ST_ACK: begin
        cmd.kind = op_rd_q ? PK_RACK : PK_WACK;
        if (emit_ok) begin
          cmd.emit = 1'b1;
          if (phase_q == 2'd2) begin
            phase_d = '0;
            if (!op_rd_q && stat_i.nack) begin
              err_d   = 1'b1;
              state_d = ST_STOP;
            end else begin
              cmd.last  = 1'b1;
              cmd.acked = ~op_rd_q;
              state_d   = ST_IDLE;
            end
          end else begin
            phase_d = phase_q + 2'd1;
          end
        end
      end
      ST_STOP: begin
        cmd.kind = PK_STOP;
        if (emit_ok) begin
          cmd.emit = 1'b1;
          if (phase_q == 2'd2) begin
            phase_d    = '0;
            cmd.last   = 1'b1;
            cmd.status = err_q ? STAT_NACK : STAT_OK;
            open_d     = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            phase_d = phase_q + 2'd1;
          end
        end
      end
      ST_IGNORE: begin
        cmd.kind = PK_HOLD;
        if (emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.status = STAT_IGNORED;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && cmd.last |=> state_q == ST_IDLE)
    else $error("sequencer not idle after last phase");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && cmd.status != STAT_OK |-> cmd.last)
    else $error("status reported before last phase");

  a_acked_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && cmd.acked |-> cmd.last && cmd.status == STAT_OK)
    else $error("ack reported with error status");

  a_stop_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STOP && cmd.emit && cmd.last |=> !open_q)
    else $error("transfer still open after stop");

  a_no_emit_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd.emit)
    else $error("phase overwrote a waiting result");

endmodule

@@ rtl/i2c_master_byte_sequencer.sv @@
// channel   direction  payload           handshake
// request   in         in_req_i (req_t)  in_valid_i / in_ready_o
// phase     out        out_rsp_o (rsp_t) out_valid_o / out_ready_i
//
// a request is accepted, then emits its bus phases; start sends start, eight bits and ack;
// eight bits and ack for write or read; stop; one hold if ignored; a write nack adds stop
// the phase sequencer emits at most one phase a cycle into a single output register
// reset leaves the bus idle with no transfer open
// a stalled output register holds the sequencer; the next request waits for the last phase
module i2c_master_byte_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  i2cms_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output i2cms_pkg::rsp_t out_rsp_o
);
  import i2cms_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  i2cms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (in_req_i.mode),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  i2cms_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (out_rsp_o)
  );

endmodule
